@@ src/shgr_pkg.sv @@
// ----------------------------------------------------------------------------
// shgr_pkg - shared types and constants of the scaled glyph renderer
// Holds the command codes, the sequencer state type, the GB2312 code layout
// and the horizontal pixel replication function.
// ----------------------------------------------------------------------------
package shgr_pkg;

	// command codes carried on the input channel
	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// GB2312 code layout: both bytes run from CODE_BASE+1 upwards
	localparam logic [7:0] CODE_BASE      = 8'hA0;
	localparam int         CODES_PER_ZONE = 94;
	localparam int         GLYPHS_PER_FONT = CODES_PER_ZONE * CODES_PER_ZONE;

	// fixed field widths
	localparam int CODE_W  = 16;
	localparam int COORD_W = 12;
	localparam int ROWY_W  = 13;
	localparam int COLOR_W = 4;
	localparam int SCALE_W = 3;
	localparam int LADDR_W = 19;
	localparam int FROW_W  = 16;
	localparam int MASK_W  = 64;
	localparam int WIDTH_W = 7;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_BAD   = 4'b1000
	} state_t;

	// repeat every pixel scl times (once for scl outside 2..4), leftmost pixel in the top bit of the mask
	function automatic logic [MASK_W-1:0] widen_row(input logic [FROW_W-1:0] row,
			input logic [SCALE_W-1:0] scl);
		logic [MASK_W-1:0] m1;
		logic [MASK_W-1:0] m2;
		logic [MASK_W-1:0] m3;
		logic [MASK_W-1:0] m4;
		logic [MASK_W-1:0] m;
		m1 = '0;
		m2 = '0;
		m3 = '0;
		m4 = '0;
		for (int j = 0; j < FROW_W; j++) begin
			m1[MASK_W-1-j] = row[FROW_W-1-j];
			for (int k = 0; k < 2; k++) m2[MASK_W-1-2*j-k] = row[FROW_W-1-j];
			for (int k = 0; k < 3; k++) m3[MASK_W-1-3*j-k] = row[FROW_W-1-j];
			for (int k = 0; k < 4; k++) m4[MASK_W-1-4*j-k] = row[FROW_W-1-j];
		end
		case (scl)
			3'd2:    m = m2;
			3'd3:    m = m3;
			3'd4:    m = m4;
			default: m = m1;
		endcase
		return m;
	endfunction

endpackage

@@ src/shgr_ram.sv @@
// ----------------------------------------------------------------------------
// shgr_ram - generic single-port synchronous RAM
// One access per cycle; read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module shgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/scaled_hanzi_glyph_renderer.sv @@
// ----------------------------------------------------------------------------
// scaled_hanzi_glyph_renderer - scaled GB2312 dot-matrix glyph renderer
// Fonts in one synchronous RAM; draws emit one scaled row a cycle unless stalled.
// ----------------------------------------------------------------------------
// A load transfer (command = 1) writes load_row into the font store at
// load_address in the cycle it is accepted and gives no result; addresses
// beyond the store are dropped. The store is not cleared at reset, so every
// word a draw will touch must be loaded first. A draw transfer (command = 0)
// with both code bytes in 0xA1..0xFE emits GLYPH_ROWS*scale results, one per
// cycle while out_stall is low, top row first; each glyph row is fetched once
// from the RAM and repeated scale times down the screen. A draw registers
// the glyph index on acceptance, reads the first row in the FETCH state
// and then sends its lines from the EMIT state, with the next row read
// overlapped with the last replica of the current one. A bad code passes
// through the BAD state and gives a single result flagged bad_code. A load
// leaves the block idle. The block holds in_stall high while a draw is in
// progress but takes the next transfer while its final result still waits
// in the output register. Scale 0 acts as 1 and scale above MAX_SCALE
// saturates; weight beyond the fonts present selects font 0.
// ----------------------------------------------------------------------------
module scaled_hanzi_glyph_renderer #(
	parameter int GLYPH_ROWS = 16,
	parameter int MAX_SCALE  = 4,
	parameter int FONT_COUNT = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic [shgr_pkg::CODE_W-1:0]    char_code,
	input  logic [shgr_pkg::COORD_W-1:0]   x_origin,
	input  logic [shgr_pkg::COORD_W-1:0]   y_origin,
	input  logic [shgr_pkg::COLOR_W-1:0]   color,
	input  logic                           weight,
	input  logic [shgr_pkg::SCALE_W-1:0]   scale,
	input  logic [shgr_pkg::LADDR_W-1:0]   load_address,
	input  logic [shgr_pkg::FROW_W-1:0]    load_row,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [shgr_pkg::ROWY_W-1:0]    row_y,
	output logic [shgr_pkg::COORD_W-1:0]   x_start,
	output logic [shgr_pkg::MASK_W-1:0]    pixel_mask,
	output logic [shgr_pkg::WIDTH_W-1:0]   row_width,
	output logic [shgr_pkg::COLOR_W-1:0]   pixel_color,
	output logic                           bad_code,
	output logic                           last
);

	import shgr_pkg::*;

	localparam int GLYPH_TOTAL = FONT_COUNT * GLYPHS_PER_FONT;
	localparam int STORE_DEPTH = GLYPH_TOTAL * GLYPH_ROWS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int GLYPH_W     = $clog2(GLYPH_TOTAL);
	localparam int ROW_W       = $clog2(GLYPH_ROWS);

	// ---------------------------------------------------------------- state
	state_t                state_q;
	logic [GLYPH_W-1:0]    glyph_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [ROW_W-1:0]      row_q;
	logic [SCALE_W-1:0]    rep_q;
	logic [SCALE_W-1:0]    scl_q;
	logic [ROWY_W-1:0]     ycur_q;
	logic [COORD_W-1:0]    x_q;
	logic [COLOR_W-1:0]    color_q;

	// output register
	logic                  out_valid_q;
	logic [ROWY_W-1:0]     row_y_q;
	logic [COORD_W-1:0]    x_start_q;
	logic [MASK_W-1:0]     pixel_mask_q;
	logic [WIDTH_W-1:0]    row_width_q;
	logic [COLOR_W-1:0]    pixel_color_q;
	logic                  bad_code_q;
	logic                  last_q;

	// ---------------------------------------------------------------- decode
	logic                  in_xfer;
	logic                  out_free;
	logic [7:0]            zone_b;
	logic [7:0]            pos_b;
	logic                  code_ok;
	logic [7:0]            zone_off;
	logic [7:0]            pos_off;
	logic [GLYPH_W-1:0]    glyph_d;
	logic [SCALE_W-1:0]    scl_d;
	logic                  load_in_range;
	logic                  rep_done;
	logic                  row_done;
	logic                  emit_go;

	// RAM port
	logic                  ram_en;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_addr;
	logic [FROW_W-1:0]     ram_rdata;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	// the output register can take a new row this cycle
	assign out_free = !out_valid_q || !out_stall;

	assign zone_b   = char_code[CODE_W-1 -: 8];
	assign pos_b    = char_code[7:0];
	assign code_ok  = (zone_b > CODE_BASE) && (zone_b <= CODE_BASE + 8'(CODES_PER_ZONE))
			&& (pos_b > CODE_BASE) && (pos_b <= CODE_BASE + 8'(CODES_PER_ZONE));
	assign zone_off = zone_b - CODE_BASE - 8'd1;
	assign pos_off  = pos_b - CODE_BASE - 8'd1;

	// glyph index: font block, then 94 glyphs per zone
	always_comb begin
		glyph_d = GLYPH_W'(CODES_PER_ZONE) * GLYPH_W'(zone_off) + GLYPH_W'(pos_off);
		if (FONT_COUNT > 1 && weight) begin
			glyph_d = glyph_d + GLYPH_W'(GLYPHS_PER_FONT);
		end
	end

	// clamp the magnification to 1..MAX_SCALE
	always_comb begin
		if (scale == '0) begin
			scl_d = SCALE_W'(1);
		end else if (scale > SCALE_W'(MAX_SCALE)) begin
			scl_d = SCALE_W'(MAX_SCALE);
		end else begin
			scl_d = scale;
		end
	end

	assign load_in_range = ({13'd0, load_address} < 32'(STORE_DEPTH));

	// replication of the current glyph row finishes with this line
	assign rep_done = (rep_q == scl_q - SCALE_W'(1));
	assign row_done = (row_q == ROW_W'(GLYPH_ROWS - 1));
	assign emit_go  = (state_q == ST_EMIT) && out_free;

	// ---------------------------------------------------------------- RAM port
	// Loads write only while idle and reads occur only during a draw, so the
	// single port never sees a collision; a load before a draw has landed by
	// the time the draw reads.
	always_comb begin
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = addr_q + ADDR_W'(1);
		case (state_q)
			ST_IDLE: begin
				ram_en   = in_xfer && (command == CMD_LOAD) && load_in_range;
				ram_we   = 1'b1;
				ram_addr = ADDR_W'(load_address);
			end
			ST_FETCH: begin
				ram_en   = 1'b1;
				ram_addr = ADDR_W'(glyph_q) * ADDR_W'(GLYPH_ROWS);
			end
			ST_EMIT: begin
				// prefetch the next glyph row while the last replica goes out
				ram_en = emit_go && rep_done && !row_done;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	shgr_ram #(
		.WIDTH (FROW_W),
		.DEPTH (STORE_DEPTH)
	) u_font_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (load_row),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && command == CMD_DRAW) begin
						state_q <= code_ok ? ST_FETCH : ST_BAD;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go && rep_done && row_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// draw context: capture on acceptance, advance per emitted line
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			glyph_q <= glyph_d;
			scl_q   <= scl_d;
			ycur_q  <= ROWY_W'(y_origin);
			x_q     <= x_origin;
			color_q <= color;
		end
		if (state_q == ST_FETCH) begin
			addr_q <= ram_addr;
			row_q  <= '0;
			rep_q  <= '0;
		end
		if (emit_go) begin
			ycur_q <= ycur_q + ROWY_W'(1);
			if (rep_done) begin
				rep_q  <= '0;
				row_q  <= row_q + ROW_W'(1);
				addr_q <= addr_q + ADDR_W'(1);
			end else begin
				rep_q <= rep_q + SCALE_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go || (state_q == ST_BAD && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			row_y_q       <= ycur_q;
			x_start_q     <= x_q;
			pixel_mask_q  <= widen_row(ram_rdata, scl_q);
			row_width_q   <= {scl_q, 4'd0};
			pixel_color_q <= color_q;
			bad_code_q    <= 1'b0;
			last_q        <= rep_done && row_done;
		end else if (state_q == ST_BAD && out_free) begin
			row_y_q       <= ycur_q;
			x_start_q     <= x_q;
			pixel_mask_q  <= '0;
			row_width_q   <= {scl_q, 4'd0};
			pixel_color_q <= color_q;
			bad_code_q    <= 1'b1;
			last_q        <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign row_y       = row_y_q;
	assign x_start     = x_start_q;
	assign pixel_mask  = pixel_mask_q;
	assign row_width   = row_width_q;
	assign pixel_color = pixel_color_q;
	assign bad_code    = bad_code_q;
	assign last        = last_q;

	// ---------------------------------------------------------------- assertions
	// no set pixel beyond the used width of the mask
	a_mask_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pixel_mask << row_width) == '0))
		else $error("pixel set beyond row_width");

	// row width always a whole multiple of the glyph width within range
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row_width[3:0] == 4'd0 && row_width >= WIDTH_W'(16)
			&& row_width <= WIDTH_W'(16 * MAX_SCALE)))
		else $error("row_width out of range");

	// a bad code result is a lone, empty, final row
	a_bad_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_code) |-> (last && pixel_mask == '0))
		else $error("malformed bad_code result");

	// the final line of a draw returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && rep_done && row_done) |=> (state_q == ST_IDLE && out_valid && last))
		else $error("draw did not finish after its final line");

endmodule
